// ===== design/pushbutton_two_channel_dimmer_core_macros.svh =====
// Assertion macros for the pushbutton dimmer checker.
// Needs nothing else; include by bare file name.
`ifndef PUSHBUTTON_TWO_CHANNEL_DIMMER_CORE_MACROS_SVH
`define PUSHBUTTON_TWO_CHANNEL_DIMMER_CORE_MACROS_SVH

// Check a property at every clock edge, reset included.
`define PTCD_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check a property only while reset is released.
`define PTCD_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

// ===== design/ptcd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the pushbutton two-channel dimmer.
// No dependencies.
package ptcd_pkg;

    // Level width default and configuration widths
    localparam int LEVEL_BITS_DEF = 8;
    localparam int CNT_W          = 7;
    localparam int DATA_W         = 32;
    localparam int ADDR_W         = 4;
    localparam int REG_IDX_W      = 2;

    // Register reset values
    localparam logic [CNT_W-1:0] SHORT_PRESS_RST  = 7'd5;
    localparam logic [CNT_W-1:0] LONG_PRESS_RST   = 7'd100;
    localparam logic [CNT_W-1:0] SAVE_TIMEOUT_RST = 7'd100;

    // Register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_SHORT_PRESS  = 2'd0,
        REG_LONG_PRESS   = 2'd1,
        REG_SAVE_TIMEOUT = 2'd2
    } t_reg_idx;

    // Lamp mode codes
    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_ON       = 2'd1,
        MODE_CHANGING = 2'd2,
        MODE_OFF      = 2'd3
    } t_mode;

    // Threshold registers handed to the core
    typedef struct packed {
        logic [CNT_W-1:0] short_ticks;
        logic [CNT_W-1:0] long_ticks;
        logic [CNT_W-1:0] save_ticks;
    } t_cfg;

endpackage

// ===== design/ptcd_req_if.sv =====
`timescale 1ns / 1ps
// Request channel interface: tick or setpoint-write word with valid/ready.
// Depends on ptcd_pkg for the default level width.
interface ptcd_req_if #(
    parameter int LEVEL_BITS = ptcd_pkg::LEVEL_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic                  button_pressed;
    logic                  channel;
    logic [LEVEL_BITS-1:0] level;

    modport source (output valid, output req_type, output button_pressed,
                    output channel, output level, input ready);
    modport sink   (input valid, input req_type, input button_pressed,
                    input channel, input level, output ready);
endinterface

// ===== design/ptcd_res_if.sv =====
`timescale 1ns / 1ps
// Result channel interface: one status word per request with valid/ready.
// Depends on ptcd_pkg for the default level width.
interface ptcd_res_if #(
    parameter int LEVEL_BITS = ptcd_pkg::LEVEL_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [LEVEL_BITS-1:0] drive_ch0;
    logic [LEVEL_BITS-1:0] drive_ch1;
    logic [LEVEL_BITS-1:0] target_ch0;
    logic [LEVEL_BITS-1:0] target_ch1;
    logic [1:0]            mode;
    logic [1:0]            target_report;
    logic [1:0]            settled_report;
    logic                  save_strobe;
    logic [LEVEL_BITS-1:0] saved_ch0;
    logic [LEVEL_BITS-1:0] saved_ch1;

    modport source (output valid, output drive_ch0, output drive_ch1,
                    output target_ch0, output target_ch1, output mode,
                    output target_report, output settled_report,
                    output save_strobe, output saved_ch0, output saved_ch1,
                    input ready);
    modport sink   (input valid, input drive_ch0, input drive_ch1,
                    input target_ch0, input target_ch1, input mode,
                    input target_report, input settled_report,
                    input save_strobe, input saved_ch0, input saved_ch1,
                    output ready);
endinterface

// ===== design/ptcd_cfg_regs.sv =====
`timescale 1ns / 1ps
// APB-style register file holding the three press/save thresholds.
// Depends on ptcd_pkg.
module ptcd_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ptcd_pkg::ADDR_W-1:0]   paddr,
    input  logic [ptcd_pkg::DATA_W-1:0]   pwdata,
    output logic [ptcd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output ptcd_pkg::t_cfg                o_cfg
);
    localparam int PAD_W = ptcd_pkg::DATA_W - ptcd_pkg::CNT_W;

    logic [ptcd_pkg::CNT_W-1:0]     r_short;
    logic [ptcd_pkg::CNT_W-1:0]     r_long;
    logic [ptcd_pkg::CNT_W-1:0]     r_save;
    logic [ptcd_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ptcd_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // Write on the access cycle; keep the low counter bits only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short <= ptcd_pkg::SHORT_PRESS_RST;
            r_long  <= ptcd_pkg::LONG_PRESS_RST;
            r_save  <= ptcd_pkg::SAVE_TIMEOUT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                ptcd_pkg::REG_SHORT_PRESS:  r_short <= pwdata[ptcd_pkg::CNT_W-1:0];
                ptcd_pkg::REG_LONG_PRESS:   r_long  <= pwdata[ptcd_pkg::CNT_W-1:0];
                ptcd_pkg::REG_SAVE_TIMEOUT: r_save  <= pwdata[ptcd_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (reg_idx)
            ptcd_pkg::REG_SHORT_PRESS:  prdata = {{PAD_W{1'b0}}, r_short};
            ptcd_pkg::REG_LONG_PRESS:   prdata = {{PAD_W{1'b0}}, r_long};
            ptcd_pkg::REG_SAVE_TIMEOUT: prdata = {{PAD_W{1'b0}}, r_save};
            default:                    prdata = '0;
        endcase
    end

    assign o_cfg.short_ticks = r_short;
    assign o_cfg.long_ticks  = r_long;
    assign o_cfg.save_ticks  = r_save;
endmodule

// ===== design/ptcd_ramp.sv =====
`timescale 1ns / 1ps
// One channel's output ramp: step drive one unit toward the setpoint.
// Depends on ptcd_pkg for the default level width.
module ptcd_ramp #(
    parameter int LEVEL_BITS = ptcd_pkg::LEVEL_BITS_DEF
) (
    input  logic                  i_enable,
    input  logic [LEVEL_BITS-1:0] i_drive,
    input  logic [LEVEL_BITS-1:0] i_target,
    input  logic                  i_ramping,
    output logic [LEVEL_BITS-1:0] o_drive,
    output logic                  o_ramping,
    output logic                  o_settled
);
    always_comb begin
        o_drive   = i_drive;
        o_ramping = i_ramping;
        o_settled = 1'b0;
        if (i_enable) begin
            if (i_drive > i_target) begin
                o_drive   = i_drive - 1'b1;
                o_ramping = 1'b1;
            end else if (i_drive < i_target) begin
                o_drive   = i_drive + 1'b1;
                o_ramping = 1'b1;
            end else begin
                // flag the first tick at the setpoint after a ramp
                o_settled = i_ramping;
                o_ramping = 1'b0;
            end
        end
    end
endmodule

// ===== design/ptcd_core.sv =====
`timescale 1ns / 1ps
// Dimmer state and per-word update: press counter, mode, setpoint walk,
// save countdown and saved store. Depends on ptcd_pkg and ptcd_ramp.
module ptcd_core #(
    parameter int LEVEL_BITS = ptcd_pkg::LEVEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ptcd_pkg::t_cfg        i_cfg,
    input  logic                  i_fire,
    input  logic                  i_req_type,
    input  logic                  i_button,
    input  logic                  i_channel,
    input  logic [LEVEL_BITS-1:0] i_level,
    output logic [LEVEL_BITS-1:0] o_drive_ch0,
    output logic [LEVEL_BITS-1:0] o_drive_ch1,
    output logic [LEVEL_BITS-1:0] o_target_ch0,
    output logic [LEVEL_BITS-1:0] o_target_ch1,
    output logic [1:0]            o_mode,
    output logic [1:0]            o_target_report,
    output logic [1:0]            o_settled_report,
    output logic                  o_save_strobe,
    output logic [LEVEL_BITS-1:0] o_saved_ch0,
    output logic [LEVEL_BITS-1:0] o_saved_ch1
);
    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};
    localparam int                    CW        = ptcd_pkg::CNT_W;
    // phase bit 0 picks the channel, bit 1 means falling
    localparam logic [1:0]            PHASE_CH0_UP = 2'd0;

    logic [CW-1:0]         r_press_count, n_press_count;
    logic                  r_short_pending, n_short_pending;
    ptcd_pkg::t_mode       r_mode, n_mode;
    logic [LEVEL_BITS-1:0] r_target [2];
    logic [LEVEL_BITS-1:0] n_target [2];
    logic [LEVEL_BITS-1:0] r_drive  [2];
    logic [LEVEL_BITS-1:0] n_drive  [2];
    logic                  r_ramping [2];
    logic                  n_ramping [2];
    logic [1:0]            r_phase, n_phase;
    logic [CW-1:0]         r_save_cd, n_save_cd;
    logic [LEVEL_BITS-1:0] r_saved [2];
    logic [LEVEL_BITS-1:0] n_saved [2];
    logic [1:0]            target_report;
    logic                  save_strobe;
    logic [LEVEL_BITS-1:0] walk_val;
    logic                  is_tick;
    logic [1:0]            settled;

    assign is_tick = !i_req_type;

    // Work out the next state for the word in the input register
    always_comb begin
        n_press_count   = r_press_count;
        n_short_pending = r_short_pending;
        n_mode          = r_mode;
        n_target        = r_target;
        n_phase         = r_phase;
        n_save_cd       = r_save_cd;
        n_saved         = r_saved;
        target_report   = 2'b00;
        save_strobe     = 1'b0;
        walk_val        = r_target[r_phase[0]];
        if (i_req_type) begin
            // setpoint write forces on, or off when both setpoints are zero
            n_target[i_channel] = i_level;
            n_mode = (n_target[0] == '0 && n_target[1] == '0) ?
                     ptcd_pkg::MODE_OFF : ptcd_pkg::MODE_ON;
            target_report = i_channel ? 2'b10 : 2'b01;
        end else begin
            // saturating press counter
            if (i_button) begin
                if (r_press_count < i_cfg.long_ticks) begin
                    n_press_count = r_press_count + 1'b1;
                end
                if (n_press_count == i_cfg.short_ticks) begin
                    n_short_pending = 1'b1;
                end
            end else begin
                n_press_count = '0;
            end

            // long press: step one setpoint one unit or turn the phase at an end stop, rearm the save timer
            if (n_press_count >= i_cfg.long_ticks) begin
                if (r_mode == ptcd_pkg::MODE_OFF) begin
                    n_target = r_saved;
                end
                n_mode   = ptcd_pkg::MODE_CHANGING;
                walk_val = n_target[r_phase[0]];
                if (!r_phase[1]) begin
                    if (walk_val != LEVEL_MAX) begin
                        n_target[r_phase[0]] = walk_val + 1'b1;
                    end else begin
                        n_phase = r_phase + 2'd1;
                    end
                end else begin
                    if (walk_val != '0) begin
                        n_target[r_phase[0]] = walk_val - 1'b1;
                    end else begin
                        n_phase = r_phase + 2'd1;
                    end
                end
                n_save_cd = i_cfg.save_ticks;
            end

            // short press acts on release
            if (n_short_pending && n_press_count == '0) begin
                n_short_pending = 1'b0;
                if (n_mode == ptcd_pkg::MODE_IDLE || n_mode == ptcd_pkg::MODE_OFF) begin
                    n_mode        = ptcd_pkg::MODE_ON;
                    n_target      = r_saved;
                    target_report = 2'b11;
                end else if (n_mode == ptcd_pkg::MODE_ON) begin
                    n_mode        = ptcd_pkg::MODE_OFF;
                    n_target[0]   = '0;
                    n_target[1]   = '0;
                    target_report = 2'b11;
                end
            end

            // released: leave dimming, run the save countdown
            if (n_press_count == '0) begin
                if (n_mode == ptcd_pkg::MODE_CHANGING) begin
                    n_mode = ptcd_pkg::MODE_ON;
                end
                if (n_save_cd != '0) begin
                    n_save_cd = n_save_cd - 1'b1;
                    if (n_save_cd == '0) begin
                        n_saved     = n_target;
                        save_strobe = 1'b1;
                    end
                end
            end
        end
    end

    // Output ramps, one per channel, advanced on ticks only
    ptcd_ramp #(.LEVEL_BITS(LEVEL_BITS)) u_ramp0 (
        .i_enable  (is_tick),
        .i_drive   (r_drive[0]),
        .i_target  (n_target[0]),
        .i_ramping (r_ramping[0]),
        .o_drive   (n_drive[0]),
        .o_ramping (n_ramping[0]),
        .o_settled (settled[0])
    );

    ptcd_ramp #(.LEVEL_BITS(LEVEL_BITS)) u_ramp1 (
        .i_enable  (is_tick),
        .i_drive   (r_drive[1]),
        .i_target  (n_target[1]),
        .i_ramping (r_ramping[1]),
        .o_drive   (n_drive[1]),
        .o_ramping (n_ramping[1]),
        .o_settled (settled[1])
    );

    // Commit the state when the word moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_count   <= '0;
            r_short_pending <= 1'b0;
            r_mode          <= ptcd_pkg::MODE_IDLE;
            r_phase         <= PHASE_CH0_UP;
            r_save_cd       <= '0;
            for (int c = 0; c < 2; c++) begin
                r_target[c]  <= '0;
                r_drive[c]   <= '0;
                r_ramping[c] <= 1'b0;
                r_saved[c]   <= '0;
            end
        end else if (i_fire) begin
            r_press_count   <= n_press_count;
            r_short_pending <= n_short_pending;
            r_mode          <= n_mode;
            r_phase         <= n_phase;
            r_save_cd       <= n_save_cd;
            r_target        <= n_target;
            r_drive         <= n_drive;
            r_ramping       <= n_ramping;
            r_saved         <= n_saved;
        end
    end

    assign o_drive_ch0      = n_drive[0];
    assign o_drive_ch1      = n_drive[1];
    assign o_target_ch0     = n_target[0];
    assign o_target_ch1     = n_target[1];
    assign o_mode           = n_mode;
    assign o_target_report  = target_report;
    assign o_settled_report = i_req_type ? 2'b00 : settled;
    assign o_save_strobe    = save_strobe;
    assign o_saved_ch0      = n_saved[0];
    assign o_saved_ch1      = n_saved[1];
endmodule

// ===== design/pushbutton_two_channel_dimmer_core.sv =====
`timescale 1ns / 1ps
// Pushbutton two-channel dimmer, top level.
// Channels: i_req (sink) carries tick words with the button level or
// setpoint writes; o_res (source) returns one status word per request:
// drive and setpoint levels, mode, report bits, save strobe, saved levels.
// The APB-style port holds three 7-bit thresholds at byte addresses 0, 4, 8
// (short press, long press, save timeout); pready is tied high.
// Throughput: one word per cycle while o_res does not stall. A word is held
// in the input register, its state update is done in a single pass of the
// core logic, and the result lands in the output register.
// When o_res stalls, the result holds and the input register takes one more
// word if it is empty; i_req.ready then drops until the result is taken.
// Reset (i_rst_n low, synchronous) empties both registers, restores the
// default thresholds and clears all dimmer state including the saved store.
// Depends on ptcd_pkg, ptcd_req_if, ptcd_res_if, ptcd_cfg_regs, ptcd_core.
module pushbutton_two_channel_dimmer_core #(
    parameter int LEVEL_BITS = ptcd_pkg::LEVEL_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ptcd_req_if.sink                    i_req,
    ptcd_res_if.source                  o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ptcd_pkg::ADDR_W-1:0] paddr,
    input  logic [ptcd_pkg::DATA_W-1:0] pwdata,
    output logic [ptcd_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    ptcd_pkg::t_cfg        cfg;
    logic                  advance;
    logic                  fire;
    logic                  r_in_valid;
    logic                  r_req_type;
    logic                  r_button;
    logic                  r_channel;
    logic [LEVEL_BITS-1:0] r_level;
    logic                  r_out_valid;
    logic [LEVEL_BITS-1:0] n_drive_ch0, n_drive_ch1;
    logic [LEVEL_BITS-1:0] n_target_ch0, n_target_ch1;
    logic [1:0]            n_mode;
    logic [1:0]            n_target_report;
    logic [1:0]            n_settled_report;
    logic                  n_save_strobe;
    logic [LEVEL_BITS-1:0] n_saved_ch0, n_saved_ch1;
    logic [LEVEL_BITS-1:0] r_drive_ch0, r_drive_ch1;
    logic [LEVEL_BITS-1:0] r_target_ch0, r_target_ch1;
    logic [1:0]            r_mode;
    logic [1:0]            r_target_report;
    logic [1:0]            r_settled_report;
    logic                  r_save_strobe;
    logic [LEVEL_BITS-1:0] r_saved_ch0, r_saved_ch1;

    ptcd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Output register frees up when empty or taken; input follows it
    assign advance     = !r_out_valid || o_res.ready;
    assign fire        = r_in_valid && advance;
    assign i_req.ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_req_type <= i_req.req_type;
            r_button   <= i_req.button_pressed;
            r_channel  <= i_req.channel;
            r_level    <= i_req.level;
        end
    end

    ptcd_core #(.LEVEL_BITS(LEVEL_BITS)) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_fire           (fire),
        .i_req_type       (r_req_type),
        .i_button         (r_button),
        .i_channel        (r_channel),
        .i_level          (r_level),
        .o_drive_ch0      (n_drive_ch0),
        .o_drive_ch1      (n_drive_ch1),
        .o_target_ch0     (n_target_ch0),
        .o_target_ch1     (n_target_ch1),
        .o_mode           (n_mode),
        .o_target_report  (n_target_report),
        .o_settled_report (n_settled_report),
        .o_save_strobe    (n_save_strobe),
        .o_saved_ch0      (n_saved_ch0),
        .o_saved_ch1      (n_saved_ch1)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_drive_ch0      <= n_drive_ch0;
            r_drive_ch1      <= n_drive_ch1;
            r_target_ch0     <= n_target_ch0;
            r_target_ch1     <= n_target_ch1;
            r_mode           <= n_mode;
            r_target_report  <= n_target_report;
            r_settled_report <= n_settled_report;
            r_save_strobe    <= n_save_strobe;
            r_saved_ch0      <= n_saved_ch0;
            r_saved_ch1      <= n_saved_ch1;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.drive_ch0      = r_drive_ch0;
    assign o_res.drive_ch1      = r_drive_ch1;
    assign o_res.target_ch0     = r_target_ch0;
    assign o_res.target_ch1     = r_target_ch1;
    assign o_res.mode           = r_mode;
    assign o_res.target_report  = r_target_report;
    assign o_res.settled_report = r_settled_report;
    assign o_res.save_strobe    = r_save_strobe;
    assign o_res.saved_ch0      = r_saved_ch0;
    assign o_res.saved_ch1      = r_saved_ch1;
endmodule

// ===== design/ptcd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the dimmer top level, and its bind.
// Depends on ptcd_pkg and pushbutton_two_channel_dimmer_core_macros.svh.
`include "pushbutton_two_channel_dimmer_core_macros.svh"

module ptcd_checker #(
    parameter int LEVEL_BITS = ptcd_pkg::LEVEL_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_res_valid,
    input logic                  i_res_ready,
    input logic [1:0]            i_mode,
    input logic [LEVEL_BITS-1:0] i_target_ch0,
    input logic [LEVEL_BITS-1:0] i_target_ch1,
    input logic                  i_save_strobe,
    input logic [LEVEL_BITS-1:0] i_saved_ch0,
    input logic [LEVEL_BITS-1:0] i_saved_ch1,
    input logic                  i_pready
);
    // no result survives reset
    `PTCD_ASSERT(a_reset_empty, i_clk, !i_rst_n |=> !i_res_valid, "result valid after reset")

    // stalled result holds
    `PTCD_ASSERT_RST(a_stall_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_target_ch0) && $stable(i_target_ch1) && $stable(i_mode), "stalled result changed")

    // a save copies exactly the reported setpoints
    `PTCD_ASSERT_RST(a_save_copy, i_clk, i_rst_n, i_res_valid && i_save_strobe |-> i_saved_ch0 == i_target_ch0 && i_saved_ch1 == i_target_ch1, "save does not match setpoints")

    // the lamp is off only with both setpoints at zero
    `PTCD_ASSERT_RST(a_off_dark, i_clk, i_rst_n, i_res_valid && i_mode == ptcd_pkg::MODE_OFF |-> i_target_ch0 == '0 && i_target_ch1 == '0, "off mode with nonzero setpoint")

    // register port never waits
    `PTCD_ASSERT(a_pready_high, i_clk, i_pready, "pready dropped")
endmodule

bind pushbutton_two_channel_dimmer_core ptcd_checker #(.LEVEL_BITS(LEVEL_BITS)) u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_mode        (o_res.mode),
    .i_target_ch0  (o_res.target_ch0),
    .i_target_ch1  (o_res.target_ch1),
    .i_save_strobe (o_res.save_strobe),
    .i_saved_ch0   (o_res.saved_ch0),
    .i_saved_ch1   (o_res.saved_ch1),
    .i_pready      (pready)
);

// ===== bench/ptcd_dimmer_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the pushbutton two-channel dimmer: watches request, status
// and register traffic, predicts every status word and compares in order.
// Depends on ptcd_pkg, ptcd_req_if and ptcd_res_if.
module ptcd_dimmer_checker #(
    parameter int LW = ptcd_pkg::LEVEL_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ptcd_req_if                         i_req_mon,
    ptcd_res_if                         i_res_mon,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [ptcd_pkg::ADDR_W-1:0] i_paddr,
    input  logic [ptcd_pkg::DATA_W-1:0] i_pwdata,
    output int                          o_fail_count,
    output int                          o_pending
);
    import ptcd_pkg::*;

    localparam int              MAX_REPORTS = 10;
    localparam logic [LW-1:0]   LVL_FULL    = '1;

    typedef struct packed {
        logic [LW-1:0] drive_ch0;
        logic [LW-1:0] drive_ch1;
        logic [LW-1:0] target_ch0;
        logic [LW-1:0] target_ch1;
        logic [1:0]    mode;
        logic [1:0]    target_report;
        logic [1:0]    settled_report;
        logic          save_strobe;
        logic [LW-1:0] saved_ch0;
        logic [LW-1:0] saved_ch1;
    } dimmer_status_t;

    // Threshold copies, tracked from the register port
    logic [CNT_W-1:0] short_ticks;
    logic [CNT_W-1:0] long_ticks;
    logic [CNT_W-1:0] save_ticks;

    // Dimmer state
    logic [CNT_W-1:0] press_count;
    logic [CNT_W-1:0] save_countdown;
    logic             short_pending;
    t_mode            lamp_mode;
    logic [1:0]       walk_phase;
    logic [LW-1:0]    target_lvl [2];
    logic [LW-1:0]    drive_lvl  [2];
    logic [LW-1:0]    saved_lvl  [2];
    logic             ramping    [2];

    dimmer_status_t   status_q [$];
    int               words_checked;

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        words_checked = 0;
    end

    function automatic string show_status(input dimmer_status_t s);
        return $sformatf("drive %0d/%0d target %0d/%0d mode %0d trep %b srep %b save %b saved %0d/%0d",
                         s.drive_ch0, s.drive_ch1, s.target_ch0, s.target_ch1, s.mode,
                         s.target_report, s.settled_report, s.save_strobe,
                         s.saved_ch0, s.saved_ch1);
    endfunction

    // Apply one request word to the state and return the status it causes
    task automatic advance_dimmer(input logic is_set, input logic pressed, input logic ch,
                                  input logic [LW-1:0] lvl, output dimmer_status_t st);
        logic [1:0] trep;
        logic [1:0] srep;
        logic       strobe;
        logic       wch;
        trep   = '0;
        srep   = '0;
        strobe = 1'b0;
        if (is_set) begin
            // Setpoint write: no counting, no ramp, mode follows the setpoints
            target_lvl[ch] = lvl;
            if (target_lvl[0] == '0 && target_lvl[1] == '0) begin
                lamp_mode = MODE_OFF;
            end else begin
                lamp_mode = MODE_ON;
            end
            trep[ch] = 1'b1;
        end else begin
            // Count the press, saturating at the long threshold
            if (pressed) begin
                if (press_count < long_ticks) press_count = press_count + 1'b1;
                if (press_count == short_ticks) short_pending = 1'b1;
            end else begin
                press_count = '0;
            end
            // Long press: step one setpoint, or turn the phase at an end stop
            if (press_count >= long_ticks) begin
                if (lamp_mode == MODE_OFF) begin
                    target_lvl[0] = saved_lvl[0];
                    target_lvl[1] = saved_lvl[1];
                end
                lamp_mode = MODE_CHANGING;
                wch = walk_phase[0];
                if (!walk_phase[1]) begin
                    if (target_lvl[wch] != LVL_FULL) target_lvl[wch] = target_lvl[wch] + 1'b1;
                    else walk_phase = walk_phase + 1'b1;
                end else begin
                    if (target_lvl[wch] != '0) target_lvl[wch] = target_lvl[wch] - 1'b1;
                    else walk_phase = walk_phase + 1'b1;
                end
                save_countdown = save_ticks;
            end
            // Short press fires on release; swallowed while changing
            if (short_pending && press_count == '0) begin
                short_pending = 1'b0;
                if (lamp_mode == MODE_IDLE || lamp_mode == MODE_OFF) begin
                    lamp_mode     = MODE_ON;
                    target_lvl[0] = saved_lvl[0];
                    target_lvl[1] = saved_lvl[1];
                    trep          = 2'b11;
                end else if (lamp_mode == MODE_ON) begin
                    lamp_mode     = MODE_OFF;
                    target_lvl[0] = '0;
                    target_lvl[1] = '0;
                    trep          = 2'b11;
                end
            end
            // Released: leave changing, run the save countdown
            if (press_count == '0) begin
                if (lamp_mode == MODE_CHANGING) lamp_mode = MODE_ON;
                if (save_countdown != '0) begin
                    save_countdown = save_countdown - 1'b1;
                    if (save_countdown == '0) begin
                        saved_lvl[0] = target_lvl[0];
                        saved_lvl[1] = target_lvl[1];
                        strobe       = 1'b1;
                    end
                end
            end
            // Step each drive toward its setpoint
            for (int c = 0; c < 2; c++) begin
                if (drive_lvl[c] > target_lvl[c]) begin
                    drive_lvl[c] = drive_lvl[c] - 1'b1;
                    ramping[c]   = 1'b1;
                end else if (drive_lvl[c] < target_lvl[c]) begin
                    drive_lvl[c] = drive_lvl[c] + 1'b1;
                    ramping[c]   = 1'b1;
                end else begin
                    srep[c]    = ramping[c];
                    ramping[c] = 1'b0;
                end
            end
        end
        st.drive_ch0      = drive_lvl[0];
        st.drive_ch1      = drive_lvl[1];
        st.target_ch0     = target_lvl[0];
        st.target_ch1     = target_lvl[1];
        st.mode           = lamp_mode;
        st.target_report  = trep;
        st.settled_report = srep;
        st.save_strobe    = strobe;
        st.saved_ch0      = saved_lvl[0];
        st.saved_ch1      = saved_lvl[1];
    endtask

    always @(posedge i_clk) begin
        dimmer_status_t want;
        dimmer_status_t got;
        if (!i_rst_n) begin
            short_ticks    = SHORT_PRESS_RST;
            long_ticks     = LONG_PRESS_RST;
            save_ticks     = SAVE_TIMEOUT_RST;
            press_count    = '0;
            save_countdown = '0;
            short_pending  = 1'b0;
            lamp_mode      = MODE_IDLE;
            walk_phase     = '0;
            for (int c = 0; c < 2; c++) begin
                target_lvl[c] = '0;
                drive_lvl[c]  = '0;
                saved_lvl[c]  = '0;
                ramping[c]    = 1'b0;
            end
            status_q.delete();
        end else begin
            // Track register writes; unmapped indexes are dropped
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:2])
                    REG_SHORT_PRESS:  short_ticks = i_pwdata[CNT_W-1:0];
                    REG_LONG_PRESS:   long_ticks  = i_pwdata[CNT_W-1:0];
                    REG_SAVE_TIMEOUT: save_ticks  = i_pwdata[CNT_W-1:0];
                    default: ;
                endcase
            end
            // Compare each taken status word with the oldest prediction
            if (i_res_mon.valid && i_res_mon.ready) begin
                got = '{i_res_mon.drive_ch0, i_res_mon.drive_ch1,
                        i_res_mon.target_ch0, i_res_mon.target_ch1, i_res_mon.mode,
                        i_res_mon.target_report, i_res_mon.settled_report,
                        i_res_mon.save_strobe, i_res_mon.saved_ch0, i_res_mon.saved_ch1};
                if (status_q.size() == 0) begin
                    if (o_fail_count < MAX_REPORTS) begin
                        $display("unexpected status word: %s", show_status(got));
                    end
                    o_fail_count++;
                end else begin
                    want = status_q.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < MAX_REPORTS) begin
                            $display("status word %0d mismatch", words_checked);
                            $display("  want %s", show_status(want));
                            $display("  got  %s", show_status(got));
                        end
                        o_fail_count++;
                    end
                    words_checked++;
                end
            end
            // Predict the status of each accepted request word
            if (i_req_mon.valid && i_req_mon.ready) begin
                advance_dimmer(i_req_mon.req_type, i_req_mon.button_pressed,
                               i_req_mon.channel, i_req_mon.level, want);
                status_q.push_back(want);
            end
        end
        o_pending = status_q.size();
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Top of the dimmer bench: clock, reset, button and setpoint stimulus,
// threshold programming and the verdict. Depends on ptcd_pkg, both channel
// interfaces, the dimmer top level and ptcd_dimmer_checker.
module tb;
    import ptcd_pkg::*;

    localparam int LW                = LEVEL_BITS_DEF;
    localparam int HALF_PERIOD       = 5;
    localparam int RESET_CYCLES      = 4;
    localparam int CYCLE_LIMIT       = 200000;
    localparam int LONG_HOLD_CYCLES  = 80;
    localparam int END_SETTLE_CYCLES = 10;
    localparam int RX_REROLL_CYCLES  = 50;

    localparam logic [ADDR_W-1:0] ADDR_SHORT_PRESS  = {REG_SHORT_PRESS, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_LONG_PRESS   = {REG_LONG_PRESS, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_SAVE_TIMEOUT = {REG_SAVE_TIMEOUT, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED     = 4'hC;
    localparam logic [LW-1:0]     LVL_FULL          = '1;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int                fail_count;
    int                pending;
    int                words_sent;
    int                cycle_count;
    int                tx_gap_pct;
    int                rx_gap_pct;
    bit                long_hold;
    bit                quiet;
    logic [CNT_W-1:0]  short_cfg;
    logic [CNT_W-1:0]  long_cfg;
    logic [CNT_W-1:0]  save_cfg;

    ptcd_req_if #(.LEVEL_BITS(LW)) u_req_ch ();
    ptcd_res_if #(.LEVEL_BITS(LW)) u_res_ch ();

    pushbutton_two_channel_dimmer_core #(.LEVEL_BITS(LW)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (u_req_ch),
        .o_res   (u_res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ptcd_dimmer_checker #(.LW(LW)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_mon    (u_req_ch),
        .i_res_mon    (u_res_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Abort a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    function automatic int pick_gap_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 5;
            2:       return 20;
            default: return 50;
        endcase
    endfunction

    // Level near one of the end stops
    function automatic logic [LW-1:0] edge_level();
        if ($urandom_range(0, 1) != 0) return LW'($urandom_range(0, 3));
        return LVL_FULL - LW'($urandom_range(0, 3));
    endfunction

    // Status side: random stall bursts, one long hold-off on request
    initial begin
        int gap;
        int span;
        u_res_ch.ready = 1'b0;
        span           = 0;
        rx_gap_pct     = pick_gap_pct();
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            span++;
            if (span >= RX_REROLL_CYCLES) begin
                span       = 0;
                rx_gap_pct = quiet ? 0 : pick_gap_pct();
            end
            if (long_hold) begin
                u_res_ch.ready = 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge i_clk);
                long_hold = 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < rx_gap_pct) begin
                u_res_ch.ready = 1'b0;
                gap = $urandom_range(1, 14);
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                u_res_ch.ready = 1'b1;
            end
        end
    end

    // Offer one request word, after an optional gap, and wait until taken
    task automatic send_word(input logic is_set, input logic pressed, input logic ch,
                             input logic [LW-1:0] lvl);
        int gap;
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            gap = $urandom_range(1, 14);
            repeat (gap) begin
                @(negedge i_clk);
                u_req_ch.valid = 1'b0;
            end
        end
        @(negedge i_clk);
        u_req_ch.valid          = 1'b1;
        u_req_ch.req_type       = is_set;
        u_req_ch.button_pressed = pressed;
        u_req_ch.channel        = ch;
        u_req_ch.level          = lvl;
        do @(posedge i_clk); while (!u_req_ch.ready);
        words_sent++;
    endtask

    task automatic tick(input logic pressed);
        send_word(1'b0, pressed, 1'($urandom_range(0, 1)), LW'($urandom_range(0, 255)));
    endtask

    task automatic setpoint(input logic ch, input logic [LW-1:0] lvl);
        send_word(1'b1, 1'($urandom_range(0, 1)), ch, lvl);
    endtask

    // Stop offering and wait until every predicted status word has come back
    task automatic settle_block();
        @(negedge i_clk);
        u_req_ch.valid = 1'b0;
        wait (pending == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Threshold in the low bits, noise above the 7-bit field
    function automatic logic [DATA_W-1:0] with_noise(input logic [CNT_W-1:0] v);
        logic [DATA_W-1:0] w;
        w            = $urandom();
        w[CNT_W-1:0] = v;
        return w;
    endfunction

    task automatic set_thresholds(input logic [CNT_W-1:0] s, input logic [CNT_W-1:0] l,
                                  input logic [CNT_W-1:0] v);
        settle_block();
        apb_write(ADDR_SHORT_PRESS, with_noise(s));
        apb_write(ADDR_LONG_PRESS, with_noise(l));
        apb_write(ADDR_SAVE_TIMEOUT, with_noise(v));
        short_cfg = s;
        long_cfg  = l;
        save_cfg  = v;
    endtask

    // Mostly well-formed press sequences shaped by the current thresholds
    task automatic run_phase(input int n_words);
        int start;
        int kind;
        int len;
        int lo;
        start = words_sent;
        while (words_sent - start < n_words) begin
            tx_gap_pct = quiet ? 0 : pick_gap_pct();
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                // Short press around the threshold, then release
                lo  = (short_cfg > 1) ? int'(short_cfg) - 1 : 1;
                len = $urandom_range(lo, int'(short_cfg) + 2);
                repeat (len) tick(1'b1);
                repeat ($urandom_range(1, 4)) tick(1'b0);
            end else if (kind < 60) begin
                // Long press, sometimes from setpoints near the end stops
                if ($urandom_range(0, 2) == 0) begin
                    setpoint(1'b0, edge_level());
                    setpoint(1'b1, edge_level());
                end
                len = int'(long_cfg) + $urandom_range(0, 30);
                repeat (len) tick(1'b1);
                if ($urandom_range(0, 3) != 0) len = int'(save_cfg) + $urandom_range(0, 3);
                else len = $urandom_range(1, int'(save_cfg));
                repeat (len) tick(1'b0);
            end else if (kind < 80) begin
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 3) == 0) begin
                        setpoint(1'($urandom_range(0, 1)), edge_level());
                    end else begin
                        setpoint(1'($urandom_range(0, 1)), LW'($urandom_range(0, 255)));
                    end
                end
            end else begin
                // Bouncy button noise
                repeat ($urandom_range(1, 6)) tick(1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        i_rst_n                 = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        u_req_ch.valid          = 1'b0;
        u_req_ch.req_type       = 1'b0;
        u_req_ch.button_pressed = 1'b0;
        u_req_ch.channel        = 1'b0;
        u_req_ch.level          = '0;
        quiet                   = 1'b0;
        long_hold               = 1'b0;
        tx_gap_pct              = 0;
        words_sent              = 0;
        short_cfg               = SHORT_PRESS_RST;
        long_cfg                = LONG_PRESS_RST;
        save_cfg                = SAVE_TIMEOUT_RST;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: small thresholds, every request kind and lamp transition
        set_thresholds(7'd2, 7'd4, 7'd3);
        apb_write(ADDR_UNMAPPED, $urandom());
        send_word(1'b0, 1'b0, 1'b0, '0);
        send_word(1'b0, 1'b0, 1'b1, LVL_FULL);
        // short press from idle turns on
        tick(1'b1);
        tick(1'b1);
        tick(1'b0);
        send_word(1'b1, 1'b1, 1'b0, LVL_FULL);
        send_word(1'b1, 1'b0, 1'b1, '0);
        send_word(1'b1, 1'b1, 1'b1, LVL_FULL);
        // short press while on turns off
        tick(1'b1);
        tick(1'b1);
        tick(1'b0);
        send_word(1'b1, 1'b0, 1'b0, '0);
        send_word(1'b1, 1'b1, 1'b1, '0);
        // long press from off, release through the save
        repeat (6) tick(1'b1);
        repeat (3) tick(1'b0);
        tick(1'b1);
        tick(1'b1);
        tick(1'b0);

        // Random phases across threshold settings
        set_thresholds(SHORT_PRESS_RST, LONG_PRESS_RST, SAVE_TIMEOUT_RST);
        run_phase(40);
        set_thresholds(7'd1, 7'd2, 7'd1);
        run_phase(150);
        set_thresholds(7'd3, 7'd8, 7'd5);
        run_phase(100);
        long_hold = 1'b1;
        run_phase(100);
        set_thresholds(7'd127, 7'd127, 7'd127);
        run_phase(100);
        set_thresholds(7'd10, 7'd4, 7'd20);
        run_phase(100);
        set_thresholds(7'd2, 7'd6, 7'd3);
        quiet = 1'b1;
        run_phase(100);

        settle_block();
        repeat (END_SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
